// ----- design/vrrp_pkg.sv -----
// Shared types and constants for the VRRP router role machine.
package vrrp_pkg;

  localparam int INTERVAL_BITS = 12;
  localparam int DOWN_BITS     = INTERVAL_BITS + 2;
  localparam int PRIO_BITS     = 8;

  localparam logic [7:0]           VER_TYPE_V3   = 8'h31;
  localparam logic [PRIO_BITS-1:0] PRIO_OWNER    = 8'd255;
  localparam logic [PRIO_BITS-1:0] PRIO_STOPPING = 8'd0;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_OWN_PRIORITY   = 2'd0;
  localparam logic [1:0] REG_ROUTER_ID      = 2'd1;
  localparam logic [1:0] REG_ADV_INTERVAL   = 2'd2;
  localparam logic [1:0] REG_PREEMPT_ENABLE = 2'd3;

  localparam logic [INTERVAL_BITS-1:0] RST_INTERVAL = INTERVAL_BITS'(100);
  localparam logic [PRIO_BITS-1:0]     RST_PRIORITY = 8'd100;
  localparam logic [7:0]               RST_ROUTER_ID = 8'd1;

  typedef enum logic [1:0] {
    ROLE_INIT   = 2'd0,
    ROLE_BACKUP = 2'd1,
    ROLE_MASTER = 2'd2
  } role_t;

  typedef enum logic [1:0] {
    ACT_TICK    = 2'd0,
    ACT_STARTUP = 2'd1,
    ACT_SHUTDOWN = 2'd2,
    ACT_ADVERT  = 2'd3
  } action_t;

  typedef struct packed {
    logic [PRIO_BITS-1:0]     own_priority;
    logic [7:0]               router_id;
    logic [INTERVAL_BITS-1:0] adv_interval;
    logic                     preempt_enable;
  } cfg_t;

  typedef struct packed {
    action_t                  action;
    logic [11:0]              pkt_length;
    logic [7:0]               ver_type;
    logic [7:0]               pkt_router_id;
    logic [PRIO_BITS-1:0]     sender_priority;
    logic [INTERVAL_BITS-1:0] pkt_interval;
    logic                     checksum_ok;
  } item_t;

  typedef struct packed {
    logic                 packet_accepted;
    logic                 release_addresses;
    logic                 announce_addresses;
    logic                 claim_addresses;
    logic [PRIO_BITS-1:0] advert_priority;
    logic                 send_advert;
    role_t                role;
  } result_t;

endpackage

// ----- design/vrrp_router_role_fsm_top.sv -----
// Top level of the VRRP router role machine: input and result registers.
//
// Usage: each event (tick, startup, shutdown or a pre-parsed advertisement
// header) is one transaction on the in_ stream; the event kind travels in
// in_tuser and the header fields in in_tdata. Every event yields exactly one
// result transaction on the out_ stream carrying the new role, the send
// request with its priority, the claim, announce and release strobes and
// the packet acceptance flag.
// An event is captured in the input register, evaluated against the role
// and timer state, and its result lands in the output register; one event
// is taken every cycle while the receiver keeps out_tready high.
// The state update and the result write happen in the same cycle, which
// sets the one-per-cycle rate.
// When the receiver stalls, the result is held and the input register
// holds the next event; in_tready drops once both are occupied.
// Synchronous reset returns the role to Initialize, stops both timers,
// sets the master interval to 100 centiseconds, restores the register
// defaults and empties both stages. Registers are to be written by the user
// over the cfg_ port only while no event is in flight; nothing enforces it.
module vrrp_router_role_fsm_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [11:0] pkt_length, [19:12] ver_type, [27:20] pkt_router_id,
  // [35:28] sender_priority, [47:36] pkt_interval, [48] checksum_ok
  input  logic [55:0] in_tdata,
  // [1:0] action
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [1:0] role, [2] send_advert, [10:3] advert_priority, [11] claim_addresses,
  // [12] announce_addresses, [13] release_addresses, [14] packet_accepted
  output logic [15:0] out_tdata,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  vrrp_pkg::cfg_t    cfg;
  vrrp_pkg::item_t   item_r, item_nxt;
  logic              item_vld_r;
  vrrp_pkg::result_t res_r, res_nxt;
  logic              res_vld_r;
  logic              advance;

  assign cfg_pready = 1'b1;

  vrrp_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .cfg     (cfg)
  );

  // The held event moves on whenever the result register is free or drains.
  assign advance   = item_vld_r && (!res_vld_r || out_tready);
  assign in_tready = !item_vld_r || advance;

  always_comb begin
    item_nxt.action          = vrrp_pkg::action_t'(in_tuser);
    item_nxt.pkt_length      = in_tdata[11:0];
    item_nxt.ver_type        = in_tdata[19:12];
    item_nxt.pkt_router_id   = in_tdata[27:20];
    item_nxt.sender_priority = in_tdata[35:28];
    item_nxt.pkt_interval    = in_tdata[47:36];
    item_nxt.checksum_ok     = in_tdata[48];
  end

  vrrp_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (advance),
    .item   (item_r),
    .cfg    (cfg),
    .result (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
      res_vld_r  <= 1'b0;
    end else begin
      if (in_tready) item_vld_r <= in_tvalid;
      if (advance) begin
        res_vld_r <= 1'b1;
      end else if (out_tready) begin
        res_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) item_r <= item_nxt;
    if (advance) res_r <= res_nxt;
  end

  assign out_tvalid = res_vld_r;
  assign out_tdata  = {1'b0, res_r};

endmodule

// ----- design/vrrp_cfg.sv -----
// Configuration register file behind the APB-style port.
module vrrp_cfg (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output vrrp_pkg::cfg_t     cfg
);

  vrrp_pkg::cfg_t cfg_r;
  vrrp_pkg::cfg_t cfg_nxt;
  logic           wr_en;

  assign wr_en = psel && penable && pwrite;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (paddr[3:2])
        vrrp_pkg::REG_OWN_PRIORITY:   cfg_nxt.own_priority   = pwdata[7:0];
        vrrp_pkg::REG_ROUTER_ID:      cfg_nxt.router_id      = pwdata[7:0];
        vrrp_pkg::REG_ADV_INTERVAL:
          cfg_nxt.adv_interval = pwdata[vrrp_pkg::INTERVAL_BITS-1:0];
        vrrp_pkg::REG_PREEMPT_ENABLE: cfg_nxt.preempt_enable = pwdata[0];
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.own_priority   <= vrrp_pkg::RST_PRIORITY;
      cfg_r.router_id      <= vrrp_pkg::RST_ROUTER_ID;
      cfg_r.adv_interval   <= vrrp_pkg::RST_INTERVAL;
      cfg_r.preempt_enable <= 1'b1;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    case (paddr[3:2])
      vrrp_pkg::REG_OWN_PRIORITY:   prdata = 32'(cfg_r.own_priority);
      vrrp_pkg::REG_ROUTER_ID:      prdata = 32'(cfg_r.router_id);
      vrrp_pkg::REG_ADV_INTERVAL:   prdata = 32'(cfg_r.adv_interval);
      vrrp_pkg::REG_PREEMPT_ENABLE: prdata = 32'(cfg_r.preempt_enable);
      default:                      prdata = '0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

// ----- design/vrrp_core.sv -----
// Role state, interval and timers; evaluates one event per enabled cycle.
module vrrp_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                fire,
  input  vrrp_pkg::item_t     item,
  input  vrrp_pkg::cfg_t      cfg,
  output vrrp_pkg::result_t   result
);

  localparam int IB = vrrp_pkg::INTERVAL_BITS;
  localparam int DB = vrrp_pkg::DOWN_BITS;

  vrrp_pkg::role_t role_r, role_nxt;
  logic [IB-1:0]   master_int_r, master_int_nxt;
  logic [DB-1:0]   down_rem_r, down_rem_nxt;
  logic            down_run_r, down_run_nxt;
  logic [IB-1:0]   adv_rem_r, adv_rem_nxt;
  logic            adv_run_r, adv_run_nxt;

  logic [DB-1:0]   down_dec;
  logic [IB-1:0]   adv_dec;
  logic            down_exp, adv_exp;
  logic            accepted, to_master, prio_zero;
  logic [IB-1:0]   mi_sel;
  logic [8:0]      prio_gap;
  logic [IB+8:0]   skew_prod;
  logic [IB-1:0]   skew;
  logic [DB-1:0]   down_full;

  // Timer countdown and acceptance checks.
  always_comb begin
    down_dec = down_rem_r - DB'(down_rem_r != '0);
    adv_dec  = adv_rem_r - IB'(adv_rem_r != '0);
    down_exp = down_run_r && (down_dec == '0);
    adv_exp  = adv_run_r && (adv_dec == '0);
    prio_zero = (item.sender_priority == vrrp_pkg::PRIO_STOPPING);
    accepted = (item.action == vrrp_pkg::ACT_ADVERT) &&
               (item.pkt_length[11:3] != '0) &&
               (item.ver_type == vrrp_pkg::VER_TYPE_V3) &&
               (item.pkt_router_id == cfg.router_id) && item.checksum_ok;
    case (item.action)
      vrrp_pkg::ACT_TICK:
        to_master = down_exp && (role_r == vrrp_pkg::ROLE_BACKUP);
      vrrp_pkg::ACT_STARTUP:
        to_master = (role_r == vrrp_pkg::ROLE_INIT) &&
                    (cfg.own_priority == vrrp_pkg::PRIO_OWNER);
      default: to_master = 1'b0;
    endcase
  end

  // Master-down time: three intervals plus the priority skew.
  always_comb begin
    if (item.action == vrrp_pkg::ACT_STARTUP) begin
      mi_sel = cfg.adv_interval;
    end else if (item.action == vrrp_pkg::ACT_ADVERT && !prio_zero) begin
      mi_sel = item.pkt_interval;
    end else begin
      mi_sel = master_int_r;
    end
    prio_gap  = 9'd256 - 9'(cfg.own_priority);
    skew_prod = (IB+9)'(prio_gap) * (IB+9)'(mi_sel);
    skew      = skew_prod[IB+7:8];
    down_full = (DB'(mi_sel) << 1) + DB'(mi_sel) + DB'(skew);
  end

  // Next role.
  always_comb begin
    role_nxt = role_r;
    if (to_master) begin
      role_nxt = vrrp_pkg::ROLE_MASTER;
    end else begin
      case (item.action)
        vrrp_pkg::ACT_STARTUP: begin
          if (role_r == vrrp_pkg::ROLE_INIT) role_nxt = vrrp_pkg::ROLE_BACKUP;
        end
        vrrp_pkg::ACT_SHUTDOWN: role_nxt = vrrp_pkg::ROLE_INIT;
        vrrp_pkg::ACT_ADVERT: begin
          if (accepted && role_r == vrrp_pkg::ROLE_MASTER && !prio_zero &&
              item.sender_priority > cfg.own_priority) begin
            role_nxt = vrrp_pkg::ROLE_BACKUP;
          end
        end
        default: role_nxt = role_r;
      endcase
    end
  end

  // Timers, interval and result strobes.
  always_comb begin
    master_int_nxt = master_int_r;
    down_rem_nxt   = down_rem_r;
    down_run_nxt   = down_run_r;
    adv_rem_nxt    = adv_rem_r;
    adv_run_nxt    = adv_run_r;
    result         = '0;
    result.packet_accepted = accepted;
    case (item.action)
      vrrp_pkg::ACT_TICK: begin
        if (down_run_r) begin
          down_rem_nxt = down_dec;
          if (down_exp) down_run_nxt = 1'b0;
        end
        if (adv_run_r) begin
          adv_rem_nxt = adv_dec;
          if (adv_exp) adv_run_nxt = 1'b0;
        end
        if (!to_master && adv_exp && role_r == vrrp_pkg::ROLE_MASTER) begin
          result.send_advert     = 1'b1;
          result.advert_priority = cfg.own_priority;
          adv_rem_nxt            = cfg.adv_interval;
          adv_run_nxt            = 1'b1;
        end
      end
      vrrp_pkg::ACT_STARTUP: begin
        if (role_r == vrrp_pkg::ROLE_INIT && !to_master) begin
          master_int_nxt           = cfg.adv_interval;
          down_rem_nxt             = down_full;
          down_run_nxt             = 1'b1;
          result.release_addresses = 1'b1;
        end
      end
      vrrp_pkg::ACT_SHUTDOWN: begin
        if (role_r == vrrp_pkg::ROLE_BACKUP) begin
          down_run_nxt             = 1'b0;
          result.release_addresses = 1'b1;
        end else if (role_r == vrrp_pkg::ROLE_MASTER) begin
          adv_run_nxt              = 1'b0;
          result.send_advert       = 1'b1;
          result.release_addresses = 1'b1;
        end
      end
      vrrp_pkg::ACT_ADVERT: begin
        if (accepted && role_r == vrrp_pkg::ROLE_BACKUP) begin
          if (prio_zero) begin
            down_rem_nxt = DB'(skew);
            down_run_nxt = 1'b1;
          end else if (!cfg.preempt_enable ||
                       item.sender_priority >= cfg.own_priority) begin
            master_int_nxt = item.pkt_interval;
            down_rem_nxt   = down_full;
            down_run_nxt   = 1'b1;
          end
        end else if (accepted && role_r == vrrp_pkg::ROLE_MASTER) begin
          if (prio_zero) begin
            result.send_advert     = 1'b1;
            result.advert_priority = cfg.own_priority;
            adv_rem_nxt            = cfg.adv_interval;
            adv_run_nxt            = 1'b1;
          end else if (item.sender_priority > cfg.own_priority) begin
            adv_run_nxt              = 1'b0;
            master_int_nxt           = item.pkt_interval;
            down_rem_nxt             = down_full;
            down_run_nxt             = 1'b1;
            result.release_addresses = 1'b1;
          end
        end
      end
      default: result.packet_accepted = accepted;
    endcase
    if (to_master) begin
      down_run_nxt              = 1'b0;
      result.claim_addresses    = 1'b1;
      result.announce_addresses = 1'b1;
      result.send_advert        = 1'b1;
      result.advert_priority    = cfg.own_priority;
      adv_rem_nxt               = cfg.adv_interval;
      adv_run_nxt               = 1'b1;
    end
    result.role = role_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      role_r       <= vrrp_pkg::ROLE_INIT;
      master_int_r <= vrrp_pkg::RST_INTERVAL;
      down_rem_r   <= '0;
      down_run_r   <= 1'b0;
      adv_rem_r    <= '0;
      adv_run_r    <= 1'b0;
    end else if (fire) begin
      role_r       <= role_nxt;
      master_int_r <= master_int_nxt;
      down_rem_r   <= down_rem_nxt;
      down_run_r   <= down_run_nxt;
      adv_rem_r    <= adv_rem_nxt;
      adv_run_r    <= adv_run_nxt;
    end
  end

endmodule

// ----- design/vrrp_checker.sv -----
// Port-level checks for the role machine, bound to the top level.
module vrrp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata
);

  // A stalled result holds its value.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  // Reset empties the result register.
  assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // Claiming addresses means becoming master with send and announce.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[11] |->
      out_tdata[1:0] == vrrp_pkg::ROLE_MASTER && out_tdata[2] && out_tdata[12] &&
      !out_tdata[13])
    else $error("claim without master transition");

  // Releasing addresses never leaves the router in the master role.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[13] |-> out_tdata[1:0] != vrrp_pkg::ROLE_MASTER)
    else $error("release while master");

  // No advertisement request carries no priority.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[2] |-> out_tdata[10:3] == 8'd0)
    else $error("priority without send request");

endmodule

bind vrrp_router_role_fsm_top vrrp_checker u_vrrp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// ----- tb/vrrp_role_checker.sv -----
// Checker for the VRRP role machine: models the block, watches both streams and compares results.
module vrrp_role_checker import vrrp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  // [11:0] pkt_length, [19:12] ver_type, [27:20] pkt_router_id,
  // [35:28] sender_priority, [47:36] pkt_interval, [48] checksum_ok
  input  logic [55:0] in_tdata,
  // [1:0] action
  input  logic [1:0]  in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  // [1:0] role, [2] send_advert, [10:3] advert_priority, [11] claim_addresses,
  // [12] announce_addresses, [13] release_addresses, [14] packet_accepted
  input  logic [15:0] out_tdata,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  input  logic        cfg_pready,
  output int          results_owed,
  output int          mismatch_count
);
  timeunit 1ns;
  timeprecision 1ps;

  cfg_t                     cfg_q;
  role_t                    role_q;
  logic [INTERVAL_BITS-1:0] master_iv_q;
  logic [DOWN_BITS-1:0]     down_cnt_q;
  logic                     down_on_q;
  logic [INTERVAL_BITS-1:0] adv_cnt_q;
  logic                     adv_on_q;
  result_t                  owed_results[$];
  int                       bad_count;

  function automatic logic [DOWN_BITS-1:0] skew_count();
    int unsigned s;
    s = ((256 - int'(cfg_q.own_priority)) * int'(master_iv_q)) / 256;
    return DOWN_BITS'(s);
  endfunction

  function automatic logic [DOWN_BITS-1:0] full_down_count();
    return DOWN_BITS'(3 * int'(master_iv_q) + int'(skew_count()));
  endfunction

  function automatic void restart_adv_timer();
    adv_cnt_q = cfg_q.adv_interval;
    adv_on_q  = 1'b1;
  endfunction

  // Advances the modeled role and timers by one event and returns the result it causes.
  function automatic result_t predict_role_step(input action_t act, input logic [55:0] hdr);
    logic [11:0]              len;
    logic [7:0]               vt;
    logic [7:0]               pid;
    logic [7:0]               sprio;
    logic [INTERVAL_BITS-1:0] pint;
    logic                     cok;
    result_t                  r;
    role_t                    was;
    logic                     to_master;
    logic                     down_exp;
    logic                     adv_exp;
    len       = hdr[11:0];
    vt        = hdr[19:12];
    pid       = hdr[27:20];
    sprio     = hdr[35:28];
    pint      = hdr[47:36];
    cok       = hdr[48];
    r         = '0;
    was       = role_q;
    to_master = 1'b0;
    down_exp  = 1'b0;
    adv_exp   = 1'b0;
    case (act)
      ACT_TICK: begin
        if (down_on_q) begin
          if (down_cnt_q != '0) down_cnt_q = down_cnt_q - 1'b1;
          if (down_cnt_q == '0) begin
            down_on_q = 1'b0;
            down_exp  = 1'b1;
          end
        end
        if (adv_on_q) begin
          if (adv_cnt_q != '0) adv_cnt_q = adv_cnt_q - 1'b1;
          if (adv_cnt_q == '0) begin
            adv_on_q = 1'b0;
            adv_exp  = 1'b1;
          end
        end
        // An expiry in a role that does not own the timer only stops it.
        if (down_exp && was == ROLE_BACKUP) begin
          to_master = 1'b1;
        end else if (adv_exp && was == ROLE_MASTER) begin
          r.send_advert     = 1'b1;
          r.advert_priority = cfg_q.own_priority;
          restart_adv_timer();
        end
      end
      ACT_STARTUP: begin
        if (was == ROLE_INIT) begin
          if (cfg_q.own_priority == PRIO_OWNER) begin
            to_master = 1'b1;
          end else begin
            master_iv_q         = cfg_q.adv_interval;
            down_cnt_q          = full_down_count();
            down_on_q           = 1'b1;
            role_q              = ROLE_BACKUP;
            r.release_addresses = 1'b1;
          end
        end
      end
      ACT_SHUTDOWN: begin
        if (was == ROLE_BACKUP) begin
          down_on_q           = 1'b0;
          role_q              = ROLE_INIT;
          r.release_addresses = 1'b1;
        end else if (was == ROLE_MASTER) begin
          adv_on_q            = 1'b0;
          r.send_advert       = 1'b1;
          r.advert_priority   = PRIO_STOPPING;
          role_q              = ROLE_INIT;
          r.release_addresses = 1'b1;
        end
      end
      ACT_ADVERT: begin
        r.packet_accepted = (len >= 12'd8) && (vt == VER_TYPE_V3) &&
                            (pid == cfg_q.router_id) && cok;
        if (r.packet_accepted && was == ROLE_BACKUP) begin
          if (sprio == PRIO_STOPPING) begin
            down_cnt_q = skew_count();
            down_on_q  = 1'b1;
          end else if (!cfg_q.preempt_enable || sprio >= cfg_q.own_priority) begin
            master_iv_q = pint;
            down_cnt_q  = full_down_count();
            down_on_q   = 1'b1;
          end
        end else if (r.packet_accepted && was == ROLE_MASTER) begin
          if (sprio == PRIO_STOPPING) begin
            r.send_advert     = 1'b1;
            r.advert_priority = cfg_q.own_priority;
            restart_adv_timer();
          end else if (sprio > cfg_q.own_priority) begin
            adv_on_q            = 1'b0;
            master_iv_q         = pint;
            down_cnt_q          = full_down_count();
            down_on_q           = 1'b1;
            role_q              = ROLE_BACKUP;
            r.release_addresses = 1'b1;
          end
        end
      end
      default: ;
    endcase
    if (to_master) begin
      role_q               = ROLE_MASTER;
      down_on_q            = 1'b0;
      r.claim_addresses    = 1'b1;
      r.announce_addresses = 1'b1;
      r.send_advert        = 1'b1;
      r.advert_priority    = cfg_q.own_priority;
      restart_adv_timer();
    end
    r.role = role_q;
    return r;
  endfunction

  always @(posedge clk) begin
    result_t want;
    result_t got;
    if (!rst_n) begin
      cfg_q.own_priority   = RST_PRIORITY;
      cfg_q.router_id      = RST_ROUTER_ID;
      cfg_q.adv_interval   = RST_INTERVAL;
      cfg_q.preempt_enable = 1'b1;
      role_q               = ROLE_INIT;
      master_iv_q          = RST_INTERVAL;
      down_cnt_q           = '0;
      down_on_q            = 1'b0;
      adv_cnt_q            = '0;
      adv_on_q             = 1'b0;
      owed_results.delete();
      bad_count            = 0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (cfg_paddr[3:2])
          REG_OWN_PRIORITY:   cfg_q.own_priority   = cfg_pwdata[7:0];
          REG_ROUTER_ID:      cfg_q.router_id      = cfg_pwdata[7:0];
          REG_ADV_INTERVAL:   cfg_q.adv_interval   = cfg_pwdata[INTERVAL_BITS-1:0];
          REG_PREEMPT_ENABLE: cfg_q.preempt_enable = cfg_pwdata[0];
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        if (owed_results.size() == 0) begin
          bad_count++;
          if (bad_count <= 10)
            $display("%0t: unexpected result transaction %h, nothing outstanding",
                     $realtime, out_tdata);
        end else begin
          want = owed_results.pop_front();
          got  = result_t'(out_tdata[14:0]);
          if (got.role !== want.role || got.send_advert !== want.send_advert ||
              got.advert_priority !== want.advert_priority ||
              got.claim_addresses !== want.claim_addresses ||
              got.announce_addresses !== want.announce_addresses ||
              got.release_addresses !== want.release_addresses ||
              got.packet_accepted !== want.packet_accepted || out_tdata[15] !== 1'b0) begin
            bad_count++;
            if (bad_count <= 10) begin
              $display("%0t: result mismatch", $realtime);
              $display({"  expected role %0d send %0b prio %0d claim %0b",
                        " announce %0b release %0b acc %0b"},
                       want.role, want.send_advert, want.advert_priority, want.claim_addresses,
                       want.announce_addresses, want.release_addresses, want.packet_accepted);
              $display({"  actual   role %0d send %0b prio %0d claim %0b",
                        " announce %0b release %0b acc %0b pad %0b"},
                       got.role, got.send_advert, got.advert_priority, got.claim_addresses,
                       got.announce_addresses, got.release_addresses, got.packet_accepted,
                       out_tdata[15]);
            end
          end
        end
      end
      if (in_tvalid && in_tready) begin
        want = predict_role_step(action_t'(in_tuser), in_tdata);
        owed_results.insert(owed_results.size(), want);
      end
    end
    results_owed   <= owed_results.size();
    mismatch_count <= bad_count;
  end

endmodule

// ----- tb/vrrp_router_role_fsm_top_tb.sv -----
// Testbench top for the VRRP router role machine: clock, reset, stimulus and verdict.
module vrrp_router_role_fsm_top_tb import vrrp_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT     = 1000000;
  localparam int DRAIN_CYCLES    = 6;
  localparam int LONG_HOLD       = 300;
  localparam int PHASES          = 8;
  localparam int ITEMS_PER_PHASE = 150;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [55:0] in_tdata;
  logic [1:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [3:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  int          results_owed;
  int          mismatch_count;
  bit          long_hold_req = 1'b0;
  int          burst_left = 0;
  logic [7:0]  cur_prio = RST_PRIORITY;
  logic [7:0]  cur_rid = RST_ROUTER_ID;
  int unsigned cycle_count = 0;

  always #5 clk = ~clk;

  vrrp_router_role_fsm_top i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  vrrp_role_checker i_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .in_tuser       (in_tuser),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .cfg_psel       (cfg_psel),
    .cfg_penable    (cfg_penable),
    .cfg_pwrite     (cfg_pwrite),
    .cfg_paddr      (cfg_paddr),
    .cfg_pwdata     (cfg_pwdata),
    .cfg_pready     (cfg_pready),
    .results_owed   (results_owed),
    .mismatch_count (mismatch_count)
  );

  function automatic logic [55:0] pack_header(input logic [11:0] len, input logic [7:0] vt,
                                               input logic [7:0] pid, input logic [7:0] sprio,
                                               input logic [11:0] pint, input logic cok);
    return {7'd0, cok, pint, sprio, pid, vt, len};
  endfunction

  // Random idle time on the sender side, with occasional bursts of back-to-back events.
  task automatic sender_pause();
    int p;
    int n;
    p = $urandom_range(0, 99);
    if (burst_left > 0) begin
      burst_left--;
      n = 0;
    end else if (p < 5) begin
      burst_left = $urandom_range(20, 60);
      n = 0;
    end else if (p < 50) begin
      n = 0;
    end else if (p < 85) begin
      n = $urandom_range(1, 3);
    end else if (p < 97) begin
      n = $urandom_range(4, 10);
    end else begin
      n = $urandom_range(20, 50);
    end
    if (n > 0) begin
      in_tvalid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic offer_event(input action_t act, input logic [55:0] hdr);
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= hdr;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sender_pause();
  endtask

  task automatic wait_results_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (results_owed != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_settings(input logic [7:0] prio, input logic [7:0] rid,
                                input logic [11:0] adv, input logic preempt);
    write_reg(REG_OWN_PRIORITY, {24'd0, prio});
    write_reg(REG_ROUTER_ID, {24'd0, rid});
    write_reg(REG_ADV_INTERVAL, {20'd0, adv});
    write_reg(REG_PREEMPT_ENABLE, {31'd0, preempt});
    cur_prio = prio;
    cur_rid  = rid;
  endtask

  // Mostly ticks and well-formed advertisements, some startups and shutdowns, the rest broken packets and noise.
  task automatic random_event();
    int         p;
    int         q;
    action_t    act;
    logic [11:0] len;
    logic [7:0]  vt;
    logic [7:0]  pid;
    logic [7:0]  sprio;
    logic [11:0] pint;
    logic        cok;
    p = $urandom_range(0, 99);
    case ($urandom_range(0, 5))
      0:       sprio = PRIO_STOPPING;
      1:       sprio = cur_prio - 8'd1;
      2:       sprio = cur_prio;
      3:       sprio = cur_prio + 8'd1;
      default: sprio = 8'($urandom);
    endcase
    q = $urandom_range(0, 99);
    if (q < 85) pint = 12'($urandom_range(0, 6));
    else if (q < 95) pint = 12'($urandom);
    else pint = 12'hFFF;
    len = ($urandom_range(0, 9) == 0) ? 12'd8 : 12'($urandom_range(8, 4095));
    vt  = VER_TYPE_V3;
    pid = cur_rid;
    cok = 1'b1;
    if (p < 55) begin
      act = ACT_TICK;
      len = 12'($urandom);
      vt  = 8'($urandom);
      pid = 8'($urandom);
      cok = 1'($urandom);
    end else if (p < 78) begin
      act = ACT_ADVERT;
    end else if (p < 85) begin
      act = ACT_ADVERT;
      case ($urandom_range(0, 4))
        0: len = 12'($urandom_range(0, 7));
        1: vt = 8'($urandom);
        2: pid = 8'($urandom);
        3: cok = 1'b0;
        default: begin
          len = 12'($urandom);
          vt  = 8'($urandom);
          pid = 8'($urandom);
          cok = 1'($urandom);
        end
      endcase
    end else if (p < 92) begin
      act = ACT_STARTUP;
    end else if (p < 96) begin
      act = ACT_SHUTDOWN;
    end else begin
      act   = action_t'($urandom_range(0, 3));
      len   = 12'($urandom);
      vt    = 8'($urandom);
      pid   = 8'($urandom);
      sprio = 8'($urandom);
      pint  = 12'($urandom);
      cok   = 1'($urandom);
    end
    offer_event(act, pack_header(len, vt, pid, sprio, pint, cok));
  endtask

  // Receiver: random readiness, with stall-free stretches and one long hold-off on request.
  initial begin
    int run;
    int pick;
    int hold_cycles;
    out_tready <= 1'b0;
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_tready <= 1'b0;
        hold_cycles = 0;
        while (hold_cycles < LONG_HOLD) begin
          @(posedge clk);
          hold_cycles++;
        end
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
          out_tready <= 1'b1;
          run = $urandom_range(1, 24);
        end else if (pick < 62) begin
          out_tready <= 1'b1;
          run = $urandom_range(100, 300);
        end else if (pick < 90) begin
          out_tready <= 1'b0;
          run = $urandom_range(1, 3);
        end else if (pick < 98) begin
          out_tready <= 1'b0;
          run = $urandom_range(4, 12);
        end else begin
          out_tready <= 1'b0;
          run = $urandom_range(20, 60);
        end
        repeat (run) @(posedge clk);
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("[vrrp_router_role_fsm_top] ERROR");
    $finish;
  end

  initial begin
    rst_n       <= 1'b0;
    in_tvalid   <= 1'b0;
    in_tdata    <= '0;
    in_tuser    <= ACT_TICK;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= '0;
    cfg_pwdata  <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed events at the reset register values.
    offer_event(ACT_TICK, '0);
    offer_event(ACT_SHUTDOWN, '0);
    offer_event(ACT_ADVERT, pack_header(12'd8, VER_TYPE_V3, 8'd1, 8'd50, 12'd5, 1'b1));
    offer_event(ACT_STARTUP, '0);
    offer_event(ACT_STARTUP, '0);
    offer_event(ACT_ADVERT, pack_header(12'd7, VER_TYPE_V3, 8'd1, 8'd200, 12'd5, 1'b1));
    offer_event(ACT_ADVERT, pack_header(12'd8, 8'h30, 8'd1, 8'd200, 12'd5, 1'b1));
    offer_event(ACT_ADVERT, pack_header(12'd8, VER_TYPE_V3, 8'd2, 8'd200, 12'd5, 1'b1));
    offer_event(ACT_ADVERT, pack_header(12'd8, VER_TYPE_V3, 8'd1, 8'd200, 12'd5, 1'b0));
    // Master stopping, then a lower priority that preemption ignores.
    offer_event(ACT_ADVERT, pack_header(12'd64, VER_TYPE_V3, 8'd1, PRIO_STOPPING, 12'd5, 1'b1));
    offer_event(ACT_ADVERT, pack_header(12'd64, VER_TYPE_V3, 8'd1, 8'd50, 12'd5, 1'b1));
    // A zero packet interval makes master-down expire on the next tick.
    offer_event(ACT_ADVERT, pack_header(12'd64, VER_TYPE_V3, 8'd1, 8'd255, 12'd0, 1'b1));
    offer_event(ACT_TICK, '0);
    offer_event(ACT_ADVERT, pack_header(12'd64, VER_TYPE_V3, 8'd1, PRIO_STOPPING, 12'd5, 1'b1));
    offer_event(ACT_ADVERT, pack_header(12'd64, VER_TYPE_V3, 8'd1, 8'd100, 12'd5, 1'b1));
    offer_event(ACT_ADVERT, pack_header(12'd64, VER_TYPE_V3, 8'd1, 8'd101, 12'hFFF, 1'b1));
    offer_event(ACT_SHUTDOWN, '0);

    // Address owner with an interval of one and preemption off.
    wait_results_drained();
    apply_settings(PRIO_OWNER, 8'd255, 12'd1, 1'b0);
    offer_event(ACT_STARTUP, '0);
    offer_event(ACT_TICK, '0);
    offer_event(ACT_TICK, '0);
    offer_event(ACT_ADVERT, pack_header(12'hFFF, VER_TYPE_V3, 8'd255, 8'd255, 12'hFFF, 1'b1));
    offer_event(ACT_SHUTDOWN, '0);
    offer_event(ACT_TICK, '1);
    wait_results_drained();
    apply_settings(8'd200, 8'd9, 12'd1, 1'b0);
    offer_event(ACT_STARTUP, '0);
    offer_event(ACT_ADVERT, pack_header(12'd8, VER_TYPE_V3, 8'd9, 8'd10, 12'd2, 1'b1));

    for (int ph = 0; ph < PHASES; ph++) begin
      wait_results_drained();
      case (ph)
        0: apply_settings(8'd100, 8'd1, 12'd3, 1'b1);
        1: apply_settings(PRIO_OWNER, 8'd255, 12'd1, 1'b0);
        2: apply_settings(8'd1, 8'd7, 12'd2, 1'b1);
        3: apply_settings(8'd254, 8'd42, 12'hFFF, 1'b1);
        4: apply_settings(8'd200, 8'd1, 12'd5, 1'b0);
        default: apply_settings(8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)),
                                12'($urandom_range(1, 8)), 1'($urandom_range(0, 1)));
      endcase
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        if (ph == 2 && k == 40) long_hold_req = 1'b1;
        random_event();
      end
    end

    wait_results_drained();
    if (mismatch_count == 0 && results_owed == 0) begin
      $display("[vrrp_router_role_fsm_top] OK");
    end else begin
      $display("[vrrp_router_role_fsm_top] ERROR");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
design/vrrp_pkg.sv
design/vrrp_cfg.sv
design/vrrp_core.sv
design/vrrp_router_role_fsm_top.sv
design/vrrp_checker.sv
tb/vrrp_role_checker.sv
tb/vrrp_router_role_fsm_top_tb.sv
